FILE: rtl/core/llq_pkg.sv
// Shared constants and types for the linked-list queue with free list.
package llq_pkg;

   localparam int NODE_COUNT = 64;
   localparam int ADDR_W     = $clog2(NODE_COUNT);
   localparam int PTR_W      = $clog2(NODE_COUNT + 1);
   localparam int VALUE_W    = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [PTR_W-1:0] PTR_NIL = PTR_W'(NODE_COUNT);

   localparam logic MODE_ENQ = 1'b0;
   localparam logic MODE_DEQ = 1'b1;

   // Access bundle from the controller to the node store
   typedef struct packed {
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
      logic               link_wr_en;
      logic [ADDR_W-1:0]  link_wr_addr;
      logic [PTR_W-1:0]   link_wr_data;
      logic               value_wr_en;
      logic [ADDR_W-1:0]  value_wr_addr;
      logic [VALUE_W-1:0] value_wr_data;
   } mem_req_type;

   function automatic logic is_nil(input logic [PTR_W-1:0] p);
      return p >= PTR_NIL;
   endfunction

endpackage

FILE: rtl/core/llq_node_store.sv
// Node store: link and value memories with registered reads.
module llq_node_store (
   input  logic                   clock,
   input  logic                   reset,
   input  llq_pkg::mem_req_type   mem_req,
   output logic [llq_pkg::PTR_W-1:0]   rd_link,
   output logic [llq_pkg::VALUE_W-1:0] rd_value
);
   import llq_pkg::*;

   logic [PTR_W-1:0]   link_mem [NODE_COUNT];
   logic [VALUE_W-1:0] value_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0] link_valid_ff;

   logic [PTR_W-1:0]   link_rd_ff;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic               rd_valid_ff;
   logic [VALUE_W-1:0] value_rd_ff;

   // valid bits: an unwritten link reads as its reset value, the next node index
   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
      end else if (mem_req.link_wr_en) begin
         link_valid_ff[mem_req.link_wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.link_wr_en) begin
         link_mem[mem_req.link_wr_addr] <= mem_req.link_wr_data;
      end
      if (mem_req.rd_en) begin
         link_rd_ff  <= link_mem[mem_req.rd_addr];
         rd_addr_ff  <= mem_req.rd_addr;
         rd_valid_ff <= link_valid_ff[mem_req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.value_wr_en) begin
         value_mem[mem_req.value_wr_addr] <= mem_req.value_wr_data;
      end
      if (mem_req.rd_en) begin
         value_rd_ff <= value_mem[mem_req.rd_addr];
      end
   end

   assign rd_link  = rd_valid_ff ? link_rd_ff : (PTR_W'(rd_addr_ff) + PTR_W'(1));
   assign rd_value = value_rd_ff;

endmodule

FILE: rtl/core/llq_ctrl.sv
// Queue controller: list pointers, two-step sequencer and result register.
module llq_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_tuser,
   input  logic [llq_pkg::VALUE_W-1:0]  req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic                         rsp_tuser,
   output logic [llq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output llq_pkg::mem_req_type         mem_req,
   input  logic [llq_pkg::PTR_W-1:0]    rd_link,
   input  logic [llq_pkg::VALUE_W-1:0]  rd_value
);
   import llq_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     head_ff, head_in;
   logic [PTR_W-1:0]     tail_ff, tail_in;
   logic [PTR_W-1:0]     free_ff, free_in;
   logic                 mode_ff, mode_in;
   logic [VALUE_W-1:0]   data_ff, data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff, rsp_ok_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 accept;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      free_in      = free_ff;
      mode_in      = mode_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_value_in = rsp_value_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_full_in  = rsp_full_ff;
      mem_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in         = req_tuser;
               data_in         = req_tdata;
               mem_req.rd_en   = 1'b1;
               // enqueue fetches the free head's link, dequeue the queue head node
               mem_req.rd_addr = (req_tuser == MODE_ENQ) ? free_ff[ADDR_W-1:0]
                                                         : head_ff[ADDR_W-1:0];
               state_in        = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            state_in     = ST_IDLE;
            if (mode_ff == MODE_ENQ) begin
               if (!is_nil(free_ff)) begin
                  free_in               = rd_link;
                  mem_req.value_wr_en   = 1'b1;
                  mem_req.value_wr_addr = free_ff[ADDR_W-1:0];
                  mem_req.value_wr_data = data_ff;
                  if (!is_nil(tail_ff)) begin
                     mem_req.link_wr_en   = 1'b1;
                     mem_req.link_wr_addr = tail_ff[ADDR_W-1:0];
                     mem_req.link_wr_data = free_ff;
                  end
                  tail_in = free_ff;
                  if (is_nil(head_ff)) begin
                     head_in = free_ff;
                  end
                  rsp_ok_in    = 1'b1;
                  rsp_empty_in = 1'b0;
                  rsp_full_in  = is_nil(rd_link);
               end else begin
                  rsp_ok_in    = 1'b0;
                  rsp_empty_in = is_nil(head_ff);
                  rsp_full_in  = 1'b1;
               end
            end else begin
               if (!is_nil(head_ff)) begin
                  rsp_value_in = rd_value;
                  // the tail's link is stale, so the last node is found by head == tail
                  if (head_ff == tail_ff) begin
                     head_in = PTR_NIL;
                     tail_in = PTR_NIL;
                  end else begin
                     head_in = rd_link;
                  end
                  mem_req.link_wr_en   = 1'b1;
                  mem_req.link_wr_addr = head_ff[ADDR_W-1:0];
                  mem_req.link_wr_data = free_ff;
                  free_in      = head_ff;
                  rsp_ok_in    = 1'b1;
                  rsp_empty_in = (head_ff == tail_ff);
                  rsp_full_in  = 1'b0;
               end else begin
                  rsp_ok_in    = 1'b0;
                  rsp_empty_in = 1'b1;
                  rsp_full_in  = is_nil(free_ff);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= PTR_NIL;
         tail_ff      <= PTR_NIL;
         free_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      data_ff      <= data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_full_ff, rsp_empty_ff, rsp_value_ff});

endmodule

FILE: rtl/core/linked_list_queue_with_free_list_core.sv
// Top level of the linked-list queue with free list.
//
//  channel | dir | tdata                              | tuser
//  req_    | in  | data_in[31:0]                      | mode (0 enq, 1 deq)
//  rsp_    | out | data_out[31:0], empty[32], full[33] | ok
//
// Each transaction first reads the link and value memories synchronously,
// then updates the pointers and writes back.
// Reset clears the pointers and the link valid bits at once; no sweep.
// A finished result sits in the output register; the next request is
// taken in the same cycle that result is accepted or once it has left.
module linked_list_queue_with_free_list_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [llq_pkg::VALUE_W-1:0]     req_tdata,   // data_in
   input  logic                            req_tuser,   // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [llq_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // data_out, empty_flag, full_flag
   output logic                            rsp_tuser    // ok
);
   import llq_pkg::*;

   mem_req_type        mem_req;
   logic [PTR_W-1:0]   rd_link;
   logic [VALUE_W-1:0] rd_value;

   llq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .mem_req    (mem_req),
      .rd_link    (rd_link),
      .rd_value   (rd_value)
   );

   llq_node_store u_store (
      .clock    (clock),
      .reset    (reset),
      .mem_req  (mem_req),
      .rd_link  (rd_link),
      .rd_value (rd_value)
   );

   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous transaction in flight");

   a_empty_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[VALUE_W] && rsp_tdata[VALUE_W+1]))
      else $error("queue reported both empty and full");

   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[VALUE_W-1:0] == '0))
      else $error("failed transaction returned nonzero data");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      (mem_req.link_wr_en || mem_req.value_wr_en) |-> !mem_req.rd_en)
      else $error("memory read issued in write-back cycle");

endmodule
